### hw/rtl/nmr_pkg.sv
// ----------------------------------------------------------------------------
// nmr_pkg
// Shared types and constants of the normal map rotation block.
// ----------------------------------------------------------------------------
package nmr_pkg;

	localparam int COEFF_WIDTH = 16;
	localparam int STEPS       = 7;

	typedef enum logic [1:0] {
		CFG_ROW_X = 2'd0,
		CFG_ROW_Y = 2'd1,
		CFG_ROW_Z = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic en;
		logic neg;
	} root_ctl_t;

endpackage

### hw/rtl/nmr_root.sv
// ----------------------------------------------------------------------------
// nmr_root
// Pipelined digit search of one encoded component, one bit per stage.
// ----------------------------------------------------------------------------
module nmr_root #(
	parameter int CW = nmr_pkg::COEFF_WIDTH
) (
	input  logic                 clk,
	input  nmr_pkg::root_ctl_t   ctl,
	input  logic [2*CW+19:0]     s_in,
	input  logic [2*CW+33:0]     r_in,
	output logic [nmr_pkg::STEPS-1:0] t_out,
	output logic                 neg_out
);

	localparam int AW = CW + 9;
	localparam int SW = 2*AW + 2;
	localparam int RW = 2*AW + 16;
	localparam int PW = SW + 9;
	localparam int WW = 2*AW + 20;
	localparam int N  = nmr_pkg::STEPS;

	logic [SW-1:0] sq_s  [N];
	logic [RW-1:0] rem_s [N];
	logic [PW-1:0] p_s   [N];
	logic [N-1:0]  t_s   [N];
	logic          neg_s [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam int B = N - 1 - i;
		logic [SW-1:0] s_prev;
		logic [RW-1:0] r_prev;
		logic [PW-1:0] p_prev;
		logic [N-1:0]  t_prev;
		logic          n_prev;
		logic [WW-1:0] trial;
		logic [WW-1:0] remw;
		logic          take;

		if (i == 0) begin : g_first
			assign s_prev = s_in;
			assign r_prev = r_in;
			assign p_prev = '0;
			assign t_prev = '0;
			assign n_prev = ctl.neg;
		end else begin : g_next
			assign s_prev = sq_s[i-1];
			assign r_prev = rem_s[i-1];
			assign p_prev = p_s[i-1];
			assign t_prev = t_s[i-1];
			assign n_prev = neg_s[i-1];
		end

		assign trial = (WW'(p_prev) << (B+1)) + (WW'(s_prev) << (2*B+2));
		assign remw  = WW'(r_prev);
		assign take  = n_prev ? (remw > trial) : (remw >= trial);

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				sq_s[i]  <= s_prev;
				neg_s[i] <= n_prev;
				if (take) begin
					rem_s[i] <= RW'(remw - trial);
					p_s[i]   <= p_prev + PW'(WW'(s_prev) << (B+2));
					t_s[i]   <= t_prev | (N'(1) << B);
				end else begin
					rem_s[i] <= r_prev;
					p_s[i]   <= p_prev;
					t_s[i]   <= t_prev;
				end
			end
		end
	end

	assign t_out   = t_s[N-1];
	assign neg_out = neg_s[N-1];

endmodule

### hw/rtl/normal_map_rotate.sv
// ----------------------------------------------------------------------------
// normal_map_rotate
// Rotates one normal-map pixel by a configured 3x3 matrix and renormalizes it.
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one pixel per request: red, green, blue bytes in s_tdata, red highest.
//   m_* returns the rotated, renormalized pixel in the same layout.
//   cfg_* writes one matrix row (index 0..2) per request; always ready.
//   rows may be written only while no pixel is in flight.
// throughput: one pixel per cycle when not stalled, set by a fully pipelined datapath.
// pipeline: input register,
//   matrix product, squares, length sum, seven bit-search stages of the
//   output byte, output register.
// reset: matrix returns to identity, pipeline is emptied.
// stall: when m_tready is low with a valid result, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
// near-zero length gives red 128, green 128, blue 255.
// ----------------------------------------------------------------------------
module normal_map_rotate #(
	parameter int COEFF_WIDTH = nmr_pkg::COEFF_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [23:0]              s_tdata,   // red_in, green_in, blue_in
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [23:0]              m_tdata,   // red_out, green_out, blue_out
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [3*COEFF_WIDTH-1:0] cfg_data
);

	localparam int CW = COEFF_WIDTH;
	localparam int FB = CW - 2;
	localparam int AW = CW + 9;
	localparam int OW = CW + 11;
	localparam int SW = 2*AW + 2;
	localparam int RW = 2*AW + 16;
	localparam int N  = nmr_pkg::STEPS;
	localparam logic [63:0] THRESH = (64'd65025 << (2*FB)) / 64'd1000000000000;

	logic [3*CW-1:0] row_q [3];
	logic            en;

	logic            v_s1, v_s2, v_s3, v_s4;
	logic [7:0]      byte_s1 [3];
	logic signed [OW-1:0] o_s2 [3];
	logic [2*AW-1:0] d_s3 [3];
	logic            neg_s3 [3];
	logic [SW-1:0]   sum_s4;
	logic [RW-1:0]   r_s4 [3];
	logic            neg_s4 [3];
	logic            zero_s4;
	logic [N-1:0]    vr_s;
	logic [N-1:0]    zr_s;
	logic [N-1:0]    t_res [3];
	logic            neg_res [3];
	logic            out_v_q;
	logic            zero_q;
	logic            negx_q;
	logic [7:0]      out_q [3];

	assign cfg_ready = 1'b1;
	assign en        = !out_v_q || m_tready;
	assign s_tready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				row_q[k] <= (3*CW)'(1) << (FB + k*CW);
			end
		end else if (cfg_valid) begin
			case (nmr_pkg::cfg_index_t'(cfg_index))
				nmr_pkg::CFG_ROW_X: row_q[0] <= cfg_data;
				nmr_pkg::CFG_ROW_Y: row_q[1] <= cfg_data;
				nmr_pkg::CFG_ROW_Z: row_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			vr_s    <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			vr_s    <= {vr_s[N-2:0], v_s4};
			out_v_q <= vr_s[N-1];
		end
	end

	// stage 1: input bytes, index 0 = x (red)
	always_ff @(posedge clk) begin
		if (en) begin
			byte_s1[0] <= s_tdata[23:16];
			byte_s1[1] <= s_tdata[15:8];
			byte_s1[2] <= s_tdata[7:0];
		end
	end

	// stage 2: matrix product
	logic signed [OW-1:0] n_ext [3];
	for (genvar j = 0; j < 3; j++) begin : g_dec
		assign n_ext[j] = OW'($signed({2'b00, byte_s1[j]} << 1) - $signed(10'sd255));
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		logic signed [OW-1:0] c [3];
		for (genvar j = 0; j < 3; j++) begin : g_c
			assign c[j] = OW'($signed(row_q[i][j*CW +: CW]));
		end
		always_ff @(posedge clk) begin
			if (en) begin
				o_s2[i] <= c[0]*n_ext[0] + c[1]*n_ext[1] + c[2]*n_ext[2];
			end
		end
	end

	// stage 3: squares
	for (genvar i = 0; i < 3; i++) begin : g_sq
		logic [AW-1:0] a;
		assign a = o_s2[i][OW-1] ? AW'(-o_s2[i]) : AW'(o_s2[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				d_s3[i]   <= (2*AW)'(a) * (2*AW)'(a);
				neg_s3[i] <= o_s2[i][OW-1];
			end
		end
	end

	// stage 4: squared length and scaled squares
	logic [SW-1:0] sum_c;
	assign sum_c = SW'(d_s3[0]) + SW'(d_s3[1]) + SW'(d_s3[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4  <= sum_c;
			zero_s4 <= 64'(sum_c) <= THRESH;
			for (int i = 0; i < 3; i++) begin
				r_s4[i]   <= RW'(d_s3[i]) * RW'(65025);
				neg_s4[i] <= neg_s3[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zr_s <= {zr_s[N-2:0], zero_s4};
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_root
		nmr_pkg::root_ctl_t ctl;
		assign ctl.en  = en;
		assign ctl.neg = neg_s4[i];
		nmr_root #(.CW(CW)) u_root (
			.clk     (clk),
			.ctl     (ctl),
			.s_in    (sum_s4),
			.r_in    (r_s4[i]),
			.t_out   (t_res[i]),
			.neg_out (neg_res[i])
		);
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= zr_s[N-1];
			negx_q <= neg_res[0];
			for (int i = 0; i < 3; i++) begin
				if (zr_s[N-1]) begin
					out_q[i] <= (i == 2) ? 8'd255 : 8'd128;
				end else if (neg_res[i]) begin
					out_q[i] <= 8'd127 - 8'(t_res[i]);
				end else begin
					out_q[i] <= 8'd128 + 8'(t_res[i]);
				end
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q[0], out_q[1], out_q[2]};

`ifndef NO_ASSERTIONS
	a_zero_blue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && zero_q |-> m_tdata[7:0] == 8'd255)
		else $error("near-zero result lacks blue 255");
	a_neg_red: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !zero_q && negx_q |-> m_tdata[23:16] <= 8'd127)
		else $error("negative x encoded above midpoint");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");
`endif

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for normal_map_rotate: corner and random pixels under
// identity, zero, extreme and random matrices, each result checked against an
// exact integer model of rotation, renormalization and byte encoding.
// ----------------------------------------------------------------------------
class pixel_scoreboard;
	logic [23:0] pending[$];
	int errors;

	function void report_error(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endfunction

	function void note_pixel(logic [23:0] expected);
		pending.push_back(expected);
	endfunction

	function void check_pixel(logic [23:0] got);
		logic [23:0] want;
		if (pending.size() == 0) begin
			report_error($sformatf("unexpected pixel %h", got));
			return;
		end
		want = pending.pop_front();
		if (got[7:0] != want[7:0])
			report_error($sformatf("blue got %0d want %0d", got[7:0], want[7:0]));
		if (got[15:8] != want[15:8])
			report_error($sformatf("green got %0d want %0d", got[15:8], want[15:8]));
		if (got[23:16] != want[23:16])
			report_error($sformatf("red got %0d want %0d", got[23:16], want[23:16]));
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = nmr_pkg::COEFF_WIDTH;
	localparam int LATENCY = 12;
	localparam int WATCHDOG = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [3*CW-1:0] cfg_data = '0;

	logic [3*CW-1:0] matrix_rows[3];
	pixel_scoreboard sb;
	int idle_cycles = 0;
	int out_wait = 0;
	bit stall_enable;

	always #10 clk = ~clk;

	normal_map_rotate u_dut (.*);

	function automatic longint coeff_of(logic [3*CW-1:0] row, int k);
		logic signed [CW-1:0] c;
		c = row[k*CW +: CW];
		return longint'(c);
	endfunction

	// exact comparison of a1*b1 against a2*b2
	function automatic int cmp_products(longint unsigned a1, longint unsigned b1,
			longint unsigned a2, longint unsigned b2);
		logic [127:0] p1, p2;
		p1 = 128'(a1) * 128'(b1);
		p2 = 128'(a2) * 128'(b2);
		return (p1 < p2) ? -1 : (p1 == p2) ? 0 : 1;
	endfunction

	function automatic logic [7:0] encode_byte(longint o, longint unsigned s);
		longint unsigned a, d, k;
		longint r;
		a = (o < 0) ? -o : o;
		d = a * a;
		k = 0;
		if (o >= 0) begin
			while (k < 127 && cmp_products(4 * (k + 1) * (k + 1), s, 65025, d) <= 0)
				k++;
			r = 128 + k;
		end else begin
			while (k < 128 && cmp_products(4 * k * k, s, 65025, d) < 0)
				k++;
			r = 128 - longint'(k);
		end
		if (r < 0) r = 0;
		if (r > 255) r = 255;
		return r[7:0];
	endfunction

	function automatic logic [23:0] rotate_pixel(logic [23:0] px);
		longint n[3];
		longint o[3];
		longint unsigned s, thresh;
		n[0] = 2 * longint'(px[23:16]) - 255;
		n[1] = 2 * longint'(px[15:8]) - 255;
		n[2] = 2 * longint'(px[7:0]) - 255;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			o[i] = 0;
			for (int j = 0; j < 3; j++)
				o[i] += coeff_of(matrix_rows[i], j) * n[j];
			s += longint'(o[i] * o[i]);
		end
		thresh = (longint'(65025) << (2 * (CW - 2))) / 64'd1000000000000;
		if (s > thresh)
			return {encode_byte(o[0], s), encode_byte(o[1], s), encode_byte(o[2], s)};
		return {8'd128, 8'd128, 8'd255};
	endfunction

	task automatic write_row(nmr_pkg::cfg_index_t idx, logic [3*CW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		matrix_rows[idx] = value;
		@(posedge clk);
	endtask

	task automatic send_pixel(logic [23:0] px);
		int gap;
		gap = $urandom_range(0, 16);
		if (stall_enable && gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(rotate_pixel(px));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coeff();
		case ($urandom_range(0, 5))
			0: return {1'b0, 1'b1, {(CW-2){1'b0}}};
			1: return {2'b11, {(CW-2){1'b0}}};
			2: return {1'b1, {(CW-1){1'b0}}};
			3: return {1'b0, {(CW-1){1'b1}}};
			4: return '0;
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic logic [3*CW-1:0] rand_row();
		logic [3*CW-1:0] r;
		r = {rand_coeff(), rand_coeff(), rand_coeff()};
		return r;
	endfunction

	// receiver: random wait per result while stalls are enabled
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_pixel(m_tdata);
			out_wait = stall_enable ? $urandom_range(0, 16) : 0;
		end
		if (out_wait > 0) begin
			out_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [23:0] corners[10];
		sb = new();
		stall_enable = 1'b0;
		matrix_rows[0] = 48'd16384;
		matrix_rows[1] = 48'd1073741824;
		matrix_rows[2] = 48'd70368744177664;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset identity with corner pixels
		corners = '{24'h000000, 24'hffffff, 24'h808080, 24'h7f7f7f, 24'hff0000,
			24'h00ff00, 24'h0000ff, 24'h7f8080, 24'h80807f, 24'haa5533};
		foreach (corners[i]) send_pixel(corners[i]);
		drain();

		// zero matrix: near-zero length
		write_row(nmr_pkg::CFG_ROW_X, '0);
		write_row(nmr_pkg::CFG_ROW_Y, '0);
		write_row(nmr_pkg::CFG_ROW_Z, '0);
		send_pixel(24'h12ab34);
		send_pixel(24'hffffff);
		drain();

		// extreme coefficients
		write_row(nmr_pkg::CFG_ROW_X, {3{1'b1, {(CW-1){1'b0}}}});
		write_row(nmr_pkg::CFG_ROW_Y, {3{1'b0, {(CW-1){1'b1}}}});
		write_row(nmr_pkg::CFG_ROW_Z, {{(CW){1'b0}}, {(CW){1'b1}}, {(CW){1'b0}}});
		foreach (corners[i]) send_pixel(corners[i]);
		drain();

		stall_enable = 1'b1;
		for (int phase = 0; phase < 11; phase++) begin
			if (phase == 5) stall_enable = 1'b0;
			if (phase == 6) stall_enable = 1'b1;
			write_row(nmr_pkg::CFG_ROW_X, rand_row());
			write_row(nmr_pkg::CFG_ROW_Y, rand_row());
			write_row(nmr_pkg::CFG_ROW_Z, rand_row());
			repeat (100) send_pixel(24'($urandom));
			drain();
		end

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

### sim.f
hw/rtl/nmr_pkg.sv
hw/rtl/nmr_root.sv
hw/rtl/normal_map_rotate.sv
bench/tb_top.sv
